>>> rtl/psir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psir_pkg
// Shared types and constants for the permutation scatter and index remap
// block: sizes, opcodes, load error codes, payload structs and range info.
// ----------------------------------------------------------------------------
package psir_pkg;

  // Number of slots in the permuted range.
  localparam int DEPTH = 1024;
  // Slot address width and counter width (a counter can hold DEPTH itself).
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Fixed field widths.
  localparam int IDX_W      = 31;
  localparam int TGT_W      = 32;
  localparam int DATA_W     = 64;
  localparam int REC_W      = 2 * DATA_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BEGIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_REMAP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    LERR_OK    = 2'd0,
    LERR_RANGE = 2'd1,
    LERR_DUP   = 2'd2,
    LERR_FULL  = 2'd3
  } load_err_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [TGT_W-1:0]  target;
    logic [DATA_W-1:0]        node_id;
    logic [DATA_W-1:0]        coord_word;
    logic [IDX_W-1:0]         index_in;
  } item_t;

  typedef struct packed {
    opcode_t           kind;
    logic [DATA_W-1:0] out_node_id;
    logic [DATA_W-1:0] out_coord_word;
    logic [IDX_W-1:0]  index_out;
    load_err_t         load_error;
    logic              perm_valid;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  // Range information derived from the configuration registers.
  typedef struct packed {
    logic [IDX_W-1:0] rbegin;
    logic [IDX_W-1:0] rend;
    logic [CW-1:0]    lim;
    logic             range_ok;
  } range_t;

endpackage
`default_nettype wire

>>> rtl/psir_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psir_item_if
// Valid/ready channel that carries one input item per transfer.
// ----------------------------------------------------------------------------
interface psir_item_if;
  import psir_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/psir_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psir_result_if
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface psir_result_if;
  import psir_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/psir_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psir_cfg_if
// Configuration write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface psir_cfg_if;
  import psir_pkg::*;

  logic    valid;
  logic    ready;
  cfg_wr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/permutation_scatter_and_index_remap_top.sv
`default_nettype none
// Results: each item is captured, executed in the execute state and its result
// registered in the output register. The read-then-write-back of the seen,
// record and map memories keeps one item in flight, with no overlap.
// Start: a sweep of the seen memory clears every entry before the next item.
// Reset: synchronous; counters clear and the same sweep of the seen memory runs
// before the first item is taken. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// permutation_scatter_and_index_remap_top
// Permutes node records by a loaded map, checks the map is a permutation and
// remaps connectivity indices through it.
// ----------------------------------------------------------------------------
module permutation_scatter_and_index_remap_top (
  input  wire logic     clk,
  input  wire logic     rst,
  psir_cfg_if.sink      cfg,
  psir_item_if.sink     items,
  psir_result_if.source results
);
  import psir_pkg::*;

  range_t rng;

  // Configuration registers and derived range information.
  psir_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .rng (rng)
  );

  // Memory-centered execution core.
  psir_core u_core (
    .clk     (clk),
    .rst     (rst),
    .rng     (rng),
    .items   (items),
    .results (results)
  );

endmodule
`default_nettype wire

>>> rtl/psir_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psir_ram
// Generic synchronous RAM: one write port and one read port, with the read
// data registered.
// ----------------------------------------------------------------------------
module psir_ram #(
  parameter int WIDTH   = 8,
  parameter int DEPTH_N = 16,
  parameter int ADDR_W  = (DEPTH_N > 2) ? $clog2(DEPTH_N) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH_N];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/psir_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psir_cfg
// Range configuration registers and the derived range information (slot
// limit and range validity) that the core uses.
// ----------------------------------------------------------------------------
module psir_cfg (
  input  wire logic            clk,
  input  wire logic            rst,
  psir_cfg_if.sink             cfg,
  output psir_pkg::range_t     rng
);
  import psir_pkg::*;

  logic [IDX_W-1:0] range_begin;
  logic [IDX_W-1:0] range_end;
  logic [IDX_W-1:0] len;
  range_t           rng_next;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_begin <= '0;
      range_end   <= '0;
    end else if (cfg.valid) begin
      if (cfg.data.index == CFG_RANGE_BEGIN) begin
        range_begin <= cfg.data.value[IDX_W-1:0];
      end else if (cfg.data.index == CFG_RANGE_END) begin
        range_end <= cfg.data.value[IDX_W-1:0];
      end
    end
  end

  // Length, slot limit and validity of the range; a reversed range is empty.
  always_comb begin
    len = (range_end >= range_begin) ? (range_end - range_begin) : '0;
    rng_next.rbegin   = range_begin;
    rng_next.rend     = range_end;
    rng_next.lim      = (len < IDX_W'(DEPTH)) ? CW'(len) : CW'(DEPTH);
    rng_next.range_ok = (range_begin <= range_end) && (len <= IDX_W'(DEPTH));
  end

  // The core sees a new range in the cycle right after the write.
  assign rng = rng_next;

endmodule
`default_nettype wire

>>> rtl/psir_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psir_core
// Sequencer and datapath around the seen, record and map memories. An item
// reads the memories when it is taken and writes back when its result is
// registered. Start and reset sweep the seen memory to zero.
// ----------------------------------------------------------------------------
module psir_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  psir_pkg::range_t rng,
  psir_item_if.sink        items,
  psir_result_if.source    results
);
  import psir_pkg::*;

  state_t state, state_next;

  // Item held for execution and its remap position.
  item_t            item;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] rel_idx;

  // Counters and sticky error.
  logic [CW-1:0] load_count, load_count_next;
  logic [CW-1:0] read_count, read_count_next;
  logic          error_seen, error_seen_next;
  logic [AW-1:0] clear_addr;

  // Output register.
  logic    out_valid;
  result_t out_data;
  result_t res;

  // Memory ports.
  logic             rd_en;
  logic             seen_we, seen_wdata, seen_rd;
  logic [AW-1:0]    seen_waddr, seen_raddr;
  logic             rec_we;
  logic [REC_W-1:0] rec_rd;
  logic             map_we;
  logic [AW-1:0]    map_rd;

  logic      accept, out_free, exec_fire;
  load_err_t lerr;
  logic      tgt_oob, idx_hit;

  assign accept   = items.valid && items.ready;
  assign out_free = !out_valid || results.ready;

  // Position of the offered index relative to the start of the range.
  assign rel_idx = items.data.index_in - rng.rbegin;

  // Seen marks: read at the load target or at the read pointer.
  assign rd_en      = accept;
  assign seen_raddr = (items.data.opcode == OP_LOAD) ? items.data.target[AW-1:0]
                                                     : read_count[AW-1:0];

  psir_ram #(.WIDTH(1), .DEPTH_N(DEPTH), .ADDR_W(AW)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (rd_en),
    .raddr (seen_raddr),
    .rdata (seen_rd)
  );

  // Records are scattered to the target slot and read back in slot order.
  psir_ram #(.WIDTH(REC_W), .DEPTH_N(DEPTH), .ADDR_W(AW)) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (item.target[AW-1:0]),
    .wdata ({item.node_id, item.coord_word}),
    .re    (rd_en),
    .raddr (read_count[AW-1:0]),
    .rdata (rec_rd)
  );

  // Map table: written in load order, read at the remap position.
  psir_ram #(.WIDTH(AW), .DEPTH_N(DEPTH), .ADDR_W(AW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (load_count[AW-1:0]),
    .wdata (item.target[AW-1:0]),
    .re    (rd_en),
    .raddr (rel_idx[AW-1:0]),
    .rdata (map_rd)
  );

  // Load checks in priority order.
  always_comb begin
    tgt_oob = item.target[TGT_W-1] || (item.target[TGT_W-2:0] >= IDX_W'(rng.lim));
    priority if (load_count >= rng.lim) begin
      lerr = LERR_FULL;
    end else if (tgt_oob) begin
      lerr = LERR_RANGE;
    end else if (seen_rd) begin
      lerr = LERR_DUP;
    end else begin
      lerr = LERR_OK;
    end
  end

  assign idx_hit = (item.index_in >= rng.rbegin) && (item.index_in < rng.rend) &&
                   (pos < IDX_W'(load_count));

  // Sequencer, counter updates and result.
  always_comb begin
    state_next      = state;
    items.ready     = 1'b0;
    exec_fire       = 1'b0;
    seen_we         = 1'b0;
    seen_waddr      = clear_addr;
    seen_wdata      = 1'b0;
    rec_we          = 1'b0;
    map_we          = 1'b0;
    load_count_next = load_count;
    read_count_next = read_count;
    error_seen_next = error_seen;
    res             = '0;
    res.kind        = item.opcode;

    unique case (item.opcode)
      OP_START: begin
        load_count_next = '0;
        read_count_next = '0;
        error_seen_next = 1'b0;
      end
      OP_LOAD: begin
        res.load_error = lerr;
        if (lerr == LERR_OK) begin
          load_count_next = load_count + CW'(1);
        end else begin
          error_seen_next = 1'b1;
        end
      end
      OP_READ: begin
        if (read_count < rng.lim) begin
          read_count_next = read_count + CW'(1);
          if (seen_rd) begin
            res.out_node_id    = rec_rd[REC_W-1:DATA_W];
            res.out_coord_word = rec_rd[DATA_W-1:0];
          end
        end
      end
      OP_REMAP: begin
        res.index_out = idx_hit ? (rng.rbegin + IDX_W'(map_rd)) : item.index_in;
      end
      default: begin
      end
    endcase
    res.perm_valid = rng.range_ok && !error_seen_next && (load_count_next == rng.lim);

    unique case (state)
      ST_CLEAR: begin
        seen_we = 1'b1;
        if (clear_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          exec_fire  = 1'b1;
          state_next = (item.opcode == OP_START) ? ST_CLEAR : ST_IDLE;
          if (item.opcode == OP_LOAD && lerr == LERR_OK) begin
            seen_we    = 1'b1;
            seen_waddr = item.target[AW-1:0];
            seen_wdata = 1'b1;
            rec_we     = 1'b1;
            map_we     = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      load_count <= '0;
      read_count <= '0;
      error_seen <= 1'b0;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + AW'(1);
      end else if (exec_fire) begin
        clear_addr <= '0;
      end
      if (exec_fire) begin
        load_count <= load_count_next;
        read_count <= read_count_next;
        error_seen <= error_seen_next;
      end
    end
  end

  // Item capture at transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= items.data;
      pos  <= rel_idx;
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // A start resets the counters and enters the clearing sweep.
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && item.opcode == OP_START) |=>
      (state == ST_CLEAR && load_count == '0 && read_count == '0 && !error_seen))
    else $error("start did not clear counters or enter the sweep");

  // A successful load advances the load count by exactly one.
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && item.opcode == OP_LOAD && lerr == LERR_OK) |=>
      (load_count == $past(load_count) + CW'(1)))
    else $error("successful load did not advance the load count");

  // A read past the end leaves the read pointer in place.
  a_read_end: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && item.opcode == OP_READ && read_count >= rng.lim) |=>
      $stable(read_count))
    else $error("read pointer moved past the end of the range");

  // While the output register is blocked, the item waits untouched.
  a_exec_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !out_free) |=> (state == ST_EXEC && $stable(item)))
    else $error("item lost while the result was blocked");

endmodule
`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Permutation scatter and index remap testbench
// Drives start, load, read and remap operations through the item channel,
// predicts every result with a cycle-free software copy of the block and
// checks each result transfer field by field. Range registers are rewritten
// between phases, and both channel sides idle and stall at several rates.
// ----------------------------------------------------------------------------
module testbench;
  import psir_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          LONG_HOLD    = 2000;
  localparam int          PHASE_ITEMS  = 40;
  localparam int          REPORT_MAX   = 10;
  // Register index that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'hF;

  logic clk = 1'b0;
  logic rst;

  psir_cfg_if    cfg_ch ();
  psir_item_if   item_ch ();
  psir_result_if res_ch ();

  permutation_scatter_and_index_remap_top dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (item_ch),
    .results (res_ch)
  );

  // Clock generation.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Predicted copy of the range registers and the block state.
  logic [IDX_W-1:0]  rng_begin = '0;
  logic [IDX_W-1:0]  rng_end   = '0;
  logic [AW-1:0]     new_pos    [DEPTH];
  bit                slot_seen  [DEPTH];
  logic [DATA_W-1:0] slot_id    [DEPTH];
  logic [DATA_W-1:0] slot_coord [DEPTH];
  logic [31:0]       loads_done  = '0;
  logic [31:0]       reads_done  = '0;
  bit                load_failed = 1'b0;

  // Stimulus and scoreboard storage.
  item_t       op_queue[$];
  result_t     results_due[$];
  int          items_added;
  int          bad_count      = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int          hold_req_cnt   = 0;
  int          hold_ack_cnt   = 0;
  int          stall_left     = 0;
  int          cycle_count    = 0;
  bit          item_taken     = 1'b0;

  function automatic logic [31:0] range_span();
    return (rng_end >= rng_begin) ? {1'b0, rng_end - rng_begin} : 32'd0;
  endfunction

  function automatic logic [31:0] slot_count();
    logic [31:0] span;
    span = range_span();
    return (span < DEPTH) ? span : 32'(DEPTH);
  endfunction

  // Applies one operation to the predicted state and returns its result.
  function automatic result_t scatter_remap_result(item_t it);
    result_t     r;
    logic [31:0] span;
    logic [31:0] lim;
    logic [31:0] tgt;
    logic [31:0] pos;
    r      = '0;
    r.kind = it.opcode;
    span   = range_span();
    lim    = slot_count();
    case (it.opcode)
      OP_START: begin
        foreach (slot_seen[i]) slot_seen[i] = 1'b0;
        loads_done  = '0;
        reads_done  = '0;
        load_failed = 1'b0;
      end
      OP_LOAD: begin
        tgt = it.target;
        if (loads_done >= lim) begin
          r.load_error = LERR_FULL;
        end else if (tgt[31] || tgt >= lim) begin
          r.load_error = LERR_RANGE;
        end else if (slot_seen[tgt]) begin
          r.load_error = LERR_DUP;
        end else begin
          new_pos[loads_done]  = tgt[AW-1:0];
          slot_seen[tgt]       = 1'b1;
          slot_id[tgt]         = it.node_id;
          slot_coord[tgt]      = it.coord_word;
          loads_done           = loads_done + 1;
        end
        if (r.load_error != LERR_OK) load_failed = 1'b1;
      end
      OP_READ: begin
        if (reads_done < lim) begin
          if (slot_seen[reads_done]) begin
            r.out_node_id    = slot_id[reads_done];
            r.out_coord_word = slot_coord[reads_done];
          end
          reads_done = reads_done + 1;
        end
      end
      default: begin
        // Indices outside the range, or at positions not loaded yet, pass through.
        r.index_out = it.index_in;
        if (it.index_in >= rng_begin && it.index_in < rng_end) begin
          pos = {1'b0, it.index_in - rng_begin};
          if (pos < loads_done && pos < DEPTH)
            r.index_out = rng_begin + IDX_W'(new_pos[pos]);
        end
      end
    endcase
    r.perm_valid = (rng_begin <= rng_end) && (span <= DEPTH) && !load_failed &&
                   (loads_done == span);
    return r;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [IDX_W-1:0] rand31();
    logic [31:0] w;
    w = $urandom();
    return w[IDX_W-1:0];
  endfunction

  task automatic add_item(opcode_t op, logic [31:0] tgt, logic [63:0] id,
                          logic [63:0] crd, logic [IDX_W-1:0] idx);
    item_t it;
    it.opcode     = op;
    it.target     = tgt;
    it.node_id    = id;
    it.coord_word = crd;
    it.index_in   = idx;
    op_queue.push_back(it);
    items_added++;
  endtask

  // Remap of an index near the range, or now and then anywhere.
  task automatic add_remap(int unsigned span_hint);
    logic [IDX_W-1:0] idx;
    logic [31:0]      off;
    off = $urandom_range(span_hint + 1);
    idx = rng_begin + off[IDX_W-1:0] - 1'b1;
    if ($urandom_range(5) == 0) idx = rand31();
    add_item(OP_REMAP, rand32(), rand64(), rand64(), idx);
  endtask

  // Start, a shuffled map with occasional faults, remaps and a read-out.
  task automatic add_sequence();
    int unsigned lim;
    int unsigned n;
    int unsigned j;
    int unsigned tmp;
    int          i;
    int unsigned k;
    int unsigned slots[$];
    logic [31:0] tgt;
    lim = slot_count();
    n   = (lim > 12) ? 12 : lim;
    add_item(OP_START, rand32(), rand64(), rand64(), rand31());
    if (lim <= 64) begin
      for (k = 0; k < lim; k++) slots.push_back(k);
      for (i = int'(lim) - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = slots[i];
        slots[i] = slots[j];
        slots[j] = tmp;
      end
    end else begin
      repeat (n) slots.push_back($urandom_range(lim - 1));
    end
    for (k = 0; k < n; k++) begin
      tgt = slots[k];
      case ($urandom_range(19))
        0: tgt = rand32();
        1: if (k > 0) tgt = slots[k-1];
        default: ;
      endcase
      add_item(OP_LOAD, tgt, rand64(), rand64(), rand31());
      if ($urandom_range(4) == 0) add_remap(n);
    end
    // An extra load after the map, always when the range has no slots.
    if (lim == 0 || $urandom_range(4) == 0)
      add_item(OP_LOAD, $urandom_range(15), rand64(), rand64(), rand31());
    repeat ($urandom_range(5, 2)) add_remap(n);
    repeat (n + $urandom_range(1)) add_item(OP_READ, rand32(), rand64(), rand64(), rand31());
  endtask

  // Random operations with random fields.
  task automatic add_noise();
    logic [31:0] tgt;
    repeat (8) begin
      tgt = $urandom_range(1) ? rand32() : 32'($urandom_range(15));
      add_item(opcode_t'($urandom_range(3)), tgt, rand64(), rand64(), rand31());
    end
  endtask

  // Register write with a random unused top data bit.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] val);
    logic [31:0] word;
    word = {1'($urandom_range(1)), val};
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_RANGE_BEGIN) rng_begin = word[IDX_W-1:0];
    else if (idx == CFG_RANGE_END) rng_end = word[IDX_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_range(logic [IDX_W-1:0] b, logic [IDX_W-1:0] e);
    write_reg(CFG_RANGE_BEGIN, b);
    write_reg(CFG_RANGE_END, e);
  endtask

  // Waits until every queued item has been transferred and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (op_queue.size() != 0 || item_ch.valid || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Item driver: a new item is offered once the previous one was transferred.
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_taken) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        item_ch.valid <= 1'b1;
        item_ch.data  <= op_queue.pop_front();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus requested long hold-offs.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      stall_left   <= LONG_HOLD;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check result transfers, then predict for item transfers.
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (results_due.size() == 0) begin
          if (bad_count < REPORT_MAX)
            $display("unexpected result: kind=%0d id=%h crd=%h idx=%h err=%0d pv=%b",
                     got.kind, got.out_node_id, got.out_coord_word, got.index_out,
                     got.load_error, got.perm_valid);
          bad_count++;
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.out_node_id !== want.out_node_id ||
              got.out_coord_word !== want.out_coord_word ||
              got.index_out !== want.index_out || got.load_error !== want.load_error ||
              got.perm_valid !== want.perm_valid) begin
            if (bad_count < REPORT_MAX) begin
              $display("mismatch expected: kind=%0d id=%h crd=%h idx=%h err=%0d pv=%b",
                       want.kind, want.out_node_id, want.out_coord_word, want.index_out,
                       want.load_error, want.perm_valid);
              $display("         actual:   kind=%0d id=%h crd=%h idx=%h err=%0d pv=%b",
                       got.kind, got.out_node_id, got.out_coord_word, got.index_out,
                       got.load_error, got.perm_valid);
            end
            bad_count++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready)
        results_due.push_back(scatter_remap_result(item_ch.data));
    end
    item_taken <= !rst && item_ch.valid && item_ch.ready;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus sequencing: reset, directed checks, then random phases.
  initial begin
    rst            = 1'b1;
    item_ch.valid  = 1'b0;
    item_ch.data   = '0;
    res_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_range(31'd100, 31'd104);
        1: set_range(31'($urandom_range(1000)), 31'($urandom_range(1000))
                     + 31'($urandom_range(12, 1)));
        2: set_range(31'h7FFF_FFF0, 31'h7FFF_FFFF);
        3: begin
          set_range(31'd500, 31'd10);
          write_reg(CFG_SPARE, rand31());
        end
        4: set_range(31'd0, 31'd0);
        5: set_range(31'd0, 31'h7FFF_FFFF);
        6: set_range(31'd3000, 31'd3000 + 31'(DEPTH));
        default: begin
          write_reg(CFG_RANGE_BEGIN, 31'($urandom_range(100000)));
          write_reg(CFG_RANGE_END, rng_begin + 31'($urandom_range(40, 1)));
        end
      endcase
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 64; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 64; end
        default: begin send_gap_pct = 21; recv_stall_pct = 21; end
      endcase
      items_added = 0;

      if (p == 0) begin
        // Full map of four, remaps in and around the range, reads past the end.
        add_item(OP_START, '0, '0, '0, '0);
        add_item(OP_LOAD, 32'd2, '0, '0, '0);
        add_item(OP_LOAD, 32'd0, '1, '1, '1);
        add_item(OP_REMAP, '1, '1, '1, 31'd101);
        add_item(OP_REMAP, '0, '0, '0, 31'd103);
        add_item(OP_LOAD, 32'd3, rand64(), rand64(), rand31());
        add_item(OP_LOAD, 32'd1, rand64(), rand64(), rand31());
        add_item(OP_LOAD, 32'd0, rand64(), rand64(), rand31());
        add_item(OP_REMAP, rand32(), rand64(), rand64(), 31'd99);
        add_item(OP_REMAP, rand32(), rand64(), rand64(), 31'd100);
        add_item(OP_REMAP, rand32(), rand64(), rand64(), 31'd104);
        add_item(OP_REMAP, rand32(), rand64(), rand64(), 31'h7FFF_FFFF);
        repeat (5) add_item(OP_READ, rand32(), rand64(), rand64(), rand31());
        // Bad targets, a duplicate, and a read of an empty slot.
        add_item(OP_START, '1, '1, '1, '1);
        add_item(OP_LOAD, 32'h8000_0000, rand64(), rand64(), rand31());
        add_item(OP_LOAD, 32'd4, rand64(), rand64(), rand31());
        add_item(OP_LOAD, 32'h7FFF_FFFF, rand64(), rand64(), rand31());
        add_item(OP_LOAD, 32'd1, rand64(), rand64(), rand31());
        add_item(OP_LOAD, 32'd1, rand64(), rand64(), rand31());
        repeat (2) add_item(OP_READ, rand32(), rand64(), rand64(), rand31());
        wait_drained();
        // Long receiver hold-off while the sender keeps offering items.
        items_added = 0;
        hold_req_cnt++;
      end

      while (items_added < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) add_noise();
        else add_sequence();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (bad_count == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
